/* rtl/utf8d_pkg.sv */
// utf8d_pkg: shared types and constants for the UTF-8 validating decoder.
// Used by utf8d_core, utf8_validating_decoder and utf8d_checker.
package utf8d_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned ScalarW = 21;

	localparam logic [ScalarW-1:0] MaxScalar   = 21'h10FFFF;
	localparam logic [ScalarW-1:0] SurrogateLo = 21'h00D800;
	localparam logic [ScalarW-1:0] SurrogateHi = 21'h00DFFF;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_LEAD  = 3'd1,
		ST_NO_CONT   = 3'd2,
		ST_OVERLONG  = 3'd3,
		ST_SURROGATE = 3'd4,
		ST_ABOVE_MAX = 3'd5,
		ST_TRUNCATED = 3'd6,
		ST_END_ERR   = 3'd7
	} status_t;

	typedef struct packed {
		logic                valid;
		logic [ScalarW-1:0]  value;
		status_t             status;
		logic                eos;
	} result_t;

endpackage

/* rtl/utf8d_core.sv */
// utf8d_core: sequence state registers and the one-byte decode/validate step.
// Depends on utf8d_pkg.
module utf8d_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [utf8d_pkg::ByteW-1:0]   data_byte,
	input  logic                          last_byte,
	output utf8d_pkg::result_t            res
);
	import utf8d_pkg::*;

	logic [1:0]         pending_q, pending_d;
	logic [ByteW-1:0]   lead_q, lead_d;
	logic               second_q, second_d;
	logic [ScalarW-1:0] partial_q, partial_d;
	logic               skip_q, skip_d;

	logic [ScalarW-1:0] shifted;
	logic [1:0]         pend_dec;
	status_t            sec_st;
	logic               err;
	status_t            err_st;

	assign shifted  = {partial_q[ScalarW-7:0], data_byte[5:0]};
	assign pend_dec = pending_q - 2'd1;

	always_comb begin
		sec_st = ST_OK;
		if (lead_q == 8'hE0 && data_byte < 8'hA0) begin
			sec_st = ST_OVERLONG;
		end else if (lead_q == 8'hED && data_byte > 8'h9F) begin
			sec_st = ST_SURROGATE;
		end else if (lead_q == 8'hF0 && data_byte < 8'h90) begin
			sec_st = ST_OVERLONG;
		end else if (lead_q == 8'hF4 && data_byte > 8'h8F) begin
			sec_st = ST_ABOVE_MAX;
		end
	end

	always_comb begin
		res        = '0;
		res.status = ST_OK;
		res.eos    = last_byte;
		pending_d  = pending_q;
		lead_d     = lead_q;
		second_d   = second_q;
		partial_d  = partial_q;
		skip_d     = skip_q;
		err        = 1'b0;
		err_st     = ST_OK;

		if (skip_q) begin
			if (last_byte) begin
				res.valid  = 1'b1;
				res.status = ST_END_ERR;
			end
		end else if (pending_q == 2'd0) begin
			if (data_byte <= 8'h7F) begin
				res.valid = 1'b1;
				res.value = {13'd0, data_byte};
			end else if (data_byte >= 8'hC2 && data_byte <= 8'hF4) begin
				if (last_byte) begin
					err    = 1'b1;
					err_st = ST_TRUNCATED;
				end else begin
					lead_d   = data_byte;
					second_d = 1'b1;
					if (data_byte <= 8'hDF) begin
						pending_d = 2'd1;
						partial_d = {16'd0, data_byte[4:0]};
					end else if (data_byte <= 8'hEF) begin
						pending_d = 2'd2;
						partial_d = {17'd0, data_byte[3:0]};
					end else begin
						pending_d = 2'd3;
						partial_d = {18'd0, data_byte[2:0]};
					end
				end
			end else begin
				err    = 1'b1;
				err_st = ST_BAD_LEAD;
			end
		end else if (data_byte[7:6] != 2'b10) begin
			err    = 1'b1;
			err_st = ST_NO_CONT;
		end else if (second_q && sec_st != ST_OK) begin
			err    = 1'b1;
			err_st = sec_st;
		end else begin
			second_d  = 1'b0;
			pending_d = pend_dec;
			partial_d = shifted;
			if (pend_dec == 2'd0) begin
				lead_d    = '0;
				partial_d = '0;
				if (shifted >= SurrogateLo && shifted <= SurrogateHi) begin
					err    = 1'b1;
					err_st = ST_SURROGATE;
				end else if (shifted > MaxScalar) begin
					err    = 1'b1;
					err_st = ST_ABOVE_MAX;
				end else begin
					res.valid = 1'b1;
					res.value = shifted;
				end
			end else if (last_byte) begin
				err    = 1'b1;
				err_st = ST_TRUNCATED;
			end
		end

		if (err) begin
			res.valid  = 1'b1;
			res.value  = '0;
			res.status = err_st;
			pending_d  = '0;
			lead_d     = '0;
			second_d   = 1'b0;
			partial_d  = '0;
			skip_d     = 1'b1;
		end

		// end of string returns everything to reset
		if (res.valid && last_byte) begin
			pending_d = '0;
			lead_d    = '0;
			second_d  = 1'b0;
			partial_d = '0;
			skip_d    = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			lead_q    <= '0;
			second_q  <= 1'b0;
			partial_q <= '0;
			skip_q    <= 1'b0;
		end else if (fire) begin
			pending_q <= pending_d;
			lead_q    <= lead_d;
			second_q  <= second_d;
			partial_q <= partial_d;
			skip_q    <= skip_d;
		end
	end

endmodule

/* rtl/utf8_validating_decoder.sv */
// utf8_validating_decoder: top level; input register, decode core, result register.
// Depends on utf8d_pkg and utf8d_core.
//
// Decodes a UTF-8 string one byte per request and returns one result per
// completed scalar value, one per error, and always one on the string's last
// byte. Bytes are registered on entry, validated and folded into the sequence
// state by one level of logic, and the result is registered on exit, so one
// byte is taken every cycle while the output side keeps up. The first error
// of a string is reported once (scalar_value 0, status nonzero); the following
// bytes give no result until the last byte, which reports status 7. A string
// that ends inside a sequence reports status 6. in_stall follows out_stall in
// the same cycle when both registers are full.
module utf8_validating_decoder (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [utf8d_pkg::ByteW-1:0]     data_byte,
	input  logic                            last_byte,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [utf8d_pkg::ScalarW-1:0]   scalar_value,
	output logic [2:0]                      status,
	output logic                            end_of_string
);
	import utf8d_pkg::*;

	logic             valid_s1;
	logic [ByteW-1:0] data_s1;
	logic             last_s1;
	logic             adv;
	logic             fire;
	result_t          res;
	result_t          out_s2;

	assign adv      = !out_s2.valid || !out_stall;
	assign fire     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	utf8d_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s2 <= '0;
		end else if (adv) begin
			out_s2.valid <= fire && res.valid;
			if (fire && res.valid) begin
				out_s2.value  <= res.value;
				out_s2.status <= res.status;
				out_s2.eos    <= res.eos;
			end
		end
	end

	assign out_valid     = out_s2.valid;
	assign scalar_value  = out_s2.value;
	assign status        = out_s2.status;
	assign end_of_string = out_s2.eos;

endmodule

/* rtl/utf8d_checker.sv */
// utf8d_checker: port-level assertions for utf8_validating_decoder, plus bind.
// Depends on utf8d_pkg.
module utf8d_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [utf8d_pkg::ScalarW-1:0]   scalar_value,
	input logic [2:0]                      status,
	input logic                            end_of_string
);
	import utf8d_pkg::*;

	a_err_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> scalar_value == '0)
		else $error("error result carries a nonzero scalar value");

	a_scalar_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> scalar_value <= MaxScalar &&
			(scalar_value < SurrogateLo || scalar_value > SurrogateHi))
		else $error("scalar value outside the Unicode scalar range");

	a_end_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_END_ERR || status == ST_TRUNCATED)
			|-> end_of_string)
		else $error("truncation or end-after-error result without end of string");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(scalar_value) &&
			$stable(status) && $stable(end_of_string))
		else $error("stalled result changed");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while the output side is free");

endmodule

bind utf8_validating_decoder utf8d_checker u_utf8d_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.scalar_value  (scalar_value),
	.status        (status),
	.end_of_string (end_of_string)
);
